[hw/rtl/weighted_roulette_sampler_update_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the weighted roulette sampler
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ROULETTE_SAMPLER_UPDATE_MACROS_SVH
`define WEIGHTED_ROULETTE_SAMPLER_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("wrsu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("wrsu assertion failed");

`endif

[hw/rtl/wrsu_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted roulette sampler package
// Shared widths, codes, power-unit constants and interface structs.
// ----------------------------------------------------------------------------
package wrsu_pkg;

  localparam int MAX_POPULATION_DEF = 1024;

  localparam int WEALTH_W = 40;
  localparam int POWER_W  = 48;
  localparam int SUM_W    = 64;
  localparam int EXP_W    = 16;
  localparam int POP_W    = 11;
  localparam int FRAC_W   = 32;
  localparam int IDX_W    = 10;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 120;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POP_SIZE = 2'd0;
  localparam logic [1:0] CFG_INIT_WEALTH = 2'd1;
  localparam logic [1:0] CFG_WEALTH_STEP = 2'd2;
  localparam logic [1:0] CFG_EXPONENT = 2'd3;

  localparam logic [WEALTH_W-1:0] WEALTH_MAX = {WEALTH_W{1'b1}};
  localparam logic [POWER_W-1:0]  POWER_MAX  = {POWER_W{1'b1}};
  localparam logic [POWER_W-1:0]  POWER_ONE  = 48'd65536;

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root chain 2^(2^-n) in UQ2.30, each step truncated.
  function automatic logic [31:0] exp_const(input int n);
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int i = 1; i < n; i++) begin
      c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

  localparam logic [31:0] EXP_C [16] = '{
    exp_const(1),  exp_const(2),  exp_const(3),  exp_const(4),
    exp_const(5),  exp_const(6),  exp_const(7),  exp_const(8),
    exp_const(9),  exp_const(10), exp_const(11), exp_const(12),
    exp_const(13), exp_const(14), exp_const(15), exp_const(16)
  };

  // Request to and response from the power unit.
  typedef struct packed {
    logic                start;
    logic [WEALTH_W-1:0] wealth;
  } pw_req_t;

  typedef struct packed {
    logic               done;
    logic [POWER_W-1:0] power;
    logic               sat;
  } pw_rsp_t;

endpackage

[hw/rtl/weighted_roulette_sampler_update.sv]
// ----------------------------------------------------------------------------
// Weighted roulette sampler with power-law weights
// Keeps wealth, power and prefix sums per entry in on-chip memories.
// ----------------------------------------------------------------------------
// Usage: an operation is sent on the input stream, its code on tuser
// (init, step or read). Each accepted init, step or read gives exactly one
// result transfer; an unused code is dropped. Configuration is written on the
// plain write port while the block is idle.
// Sequence: a read fetches the entry wealth and then presents its result. The
// power unit runs a normalize shift of up to 39 places and two 16-pass
// loops. Init runs the power unit and then fills the table entry by entry.
// Step forms the target, checks both ends, runs a binary search of up to
// log2 of the population probes, fetches the chosen entry, runs the power
// unit, and sweeps each prefix sum from the chosen entry to the last through
// the single read/write port pair of the prefix memory. One item is handled
// at a time.
// Reset clears control state and the total; table contents are undefined
// until an init. A result waits in the output register while the receiver
// stalls, and the next item is still accepted and processed up to its
// result, which then waits for the output register to free up.
// ----------------------------------------------------------------------------
module weighted_roulette_sampler_update #(
  parameter int MAX_POPULATION = wrsu_pkg::MAX_POPULATION_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [wrsu_pkg::WEALTH_W-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: random_fraction [31:0], entry_index [41:32], zero pad [47:42]
  input  logic [wrsu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: operation [1:0]
  input  logic [1:0]                          s_axis_tuser,
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: chosen_index [9:0], entry_wealth [49:10], total_power [113:50],
  // power_saturated [114], zero pad [119:115]
  output logic [wrsu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import wrsu_pkg::*;

  localparam int AW = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
  localparam int NW = AW + 1;
  localparam int CW = (NW > POP_W) ? NW : POP_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT_PW, ST_INIT_FILL, ST_MUL_LO, ST_MUL_HI, ST_TGT, ST_CHK0,
    ST_CHKN, ST_BS_ISSUE, ST_BS_CMP, ST_RDW, ST_PWR_START, ST_PWR_WAIT,
    ST_SWEEP, ST_READ, ST_RESULT
  } state_e;

  // Configuration registers.
  logic [POP_W-1:0]    pop_size_q;
  logic [WEALTH_W-1:0] init_wealth_q;
  logic [WEALTH_W-1:0] wealth_step_q;
  logic [EXP_W-1:0]    exponent_q;

  state_e              state_q, state_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SUM_W-1:0]    total_q, total_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic [POWER_W-1:0]  pw_q, pw_d;
  logic                sat_q, sat_d;
  logic [AW-1:0]       i_q, i_d;
  logic [63:0]         plo_q, plo_d;
  logic [63:0]         phi_q, phi_d;
  logic [SUM_W-1:0]    target_q, target_d;
  logic [AW-1:0]       lo_q, lo_d;
  logic [AW-1:0]       hi_q, hi_d;
  logic [AW-1:0]       mid_q, mid_d;
  logic [AW-1:0]       ci_q, ci_d;
  logic [WEALTH_W-1:0] w_q, w_d;
  logic [POWER_W-1:0]  old_q, old_d;
  logic [SUM_W-1:0]    delta_q, delta_d;
  logic [NW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_addr_q, pend_addr_d;
  logic [IDX_W-1:0]    res_idx_q, res_idx_d;
  logic [WEALTH_W-1:0] res_wealth_q, res_wealth_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Memories.
  logic [WEALTH_W-1:0] wealth_mem [MAX_POPULATION];
  logic [POWER_W-1:0]  power_mem [MAX_POPULATION];
  logic [SUM_W-1:0]    prefix_mem [MAX_POPULATION];
  logic [WEALTH_W-1:0] wealth_rd_q;
  logic [POWER_W-1:0]  power_rd_q;
  logic [SUM_W-1:0]    prefix_rd_q;

  logic                wealth_we, power_we, prefix_we;
  logic [AW-1:0]       wealth_waddr, power_waddr, prefix_waddr;
  logic [AW-1:0]       wp_raddr, prefix_raddr;
  logic [WEALTH_W-1:0] wealth_wdata;
  logic [POWER_W-1:0]  power_wdata;
  logic [SUM_W-1:0]    prefix_wdata;

  logic                s_fire;
  logic                out_free;
  logic [CW-1:0]       pop_ext;
  logic [NW-1:0]       n_act;
  logic [AW-1:0]       nm1;
  logic [WEALTH_W:0]   w_sum;
  logic [WEALTH_W-1:0] w_new;
  logic [SUM_W-1:0]    fill_sum;
  logic [SUM_W-1:0]    pw_delta;
  logic                idx_in_range;

  pw_req_t             pw_req;
  pw_rsp_t             pw_rsp;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Active entry count, clamped to [1, MAX_POPULATION].
  always_comb begin
    pop_ext = CW'(pop_size_q);
    if (pop_ext == '0) begin
      n_act = NW'(1);
    end else if (pop_ext > CW'(MAX_POPULATION)) begin
      n_act = NW'(MAX_POPULATION);
    end else begin
      n_act = NW'(pop_ext);
    end
  end
  assign nm1 = AW'(n_act - NW'(1));

  // Saturating wealth update of the chosen entry.
  assign w_sum        = {1'b0, wealth_rd_q} + {1'b0, wealth_step_q};
  assign w_new        = w_sum[WEALTH_W] ? WEALTH_MAX : w_sum[WEALTH_W-1:0];
  assign fill_sum     = acc_q + SUM_W'(pw_q);
  assign pw_delta     = SUM_W'(pw_rsp.power) - SUM_W'(old_q);
  assign idx_in_range = (32'(idx_q) < 32'(MAX_POPULATION));

  // Power unit request.
  always_comb begin
    pw_req.start  = (s_fire && s_axis_tuser == OP_INIT) || (state_q == ST_PWR_START);
    pw_req.wealth = (state_q == ST_PWR_START) ? w_new : init_wealth_q;
  end

  wrsu_power u_power (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exponent_i (exponent_q),
    .req_i      (pw_req),
    .rsp_o      (pw_rsp)
  );

  // Memory port selection.
  always_comb begin
    wealth_we    = 1'b0;
    power_we     = 1'b0;
    prefix_we    = 1'b0;
    wealth_waddr = i_q;
    power_waddr  = i_q;
    prefix_waddr = i_q;
    wealth_wdata = init_wealth_q;
    power_wdata  = pw_q;
    prefix_wdata = fill_sum;
    wp_raddr     = (state_q == ST_RDW) ? ci_q : AW'(s_axis_tdata[41:32]);
    prefix_raddr = '0;
    case (state_q)
      ST_INIT_FILL: begin
        wealth_we = 1'b1;
        power_we  = 1'b1;
        prefix_we = 1'b1;
      end
      ST_PWR_WAIT: begin
        wealth_we    = pw_rsp.done;
        power_we     = pw_rsp.done;
        wealth_waddr = ci_q;
        power_waddr  = ci_q;
        wealth_wdata = w_q;
        power_wdata  = pw_rsp.power;
      end
      ST_SWEEP: begin
        prefix_we    = pend_q;
        prefix_waddr = pend_addr_q;
        prefix_wdata = prefix_rd_q + delta_q;
        prefix_raddr = rd_ptr_q[AW-1:0];
      end
      ST_CHK0:     prefix_raddr = nm1;
      ST_BS_ISSUE: prefix_raddr = AW'(lo_q + ((hi_q - lo_q) >> 1));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wealth_we) begin
      wealth_mem[wealth_waddr] <= wealth_wdata;
    end
    wealth_rd_q <= wealth_mem[wp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (power_we) begin
      power_mem[power_waddr] <= power_wdata;
    end
    power_rd_q <= power_mem[wp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (prefix_we) begin
      prefix_mem[prefix_waddr] <= prefix_wdata;
    end
    prefix_rd_q <= prefix_mem[prefix_raddr];
  end

  // Operation sequencer.
  always_comb begin
    state_d      = state_q;
    frac_d       = frac_q;
    idx_d        = idx_q;
    total_d      = total_q;
    acc_d        = acc_q;
    pw_d         = pw_q;
    sat_d        = sat_q;
    i_d          = i_q;
    plo_d        = plo_q;
    phi_d        = phi_q;
    target_d     = target_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    ci_d         = ci_q;
    w_d          = w_q;
    old_d        = old_q;
    delta_d      = delta_q;
    rd_ptr_d     = rd_ptr_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    res_idx_d    = res_idx_q;
    res_wealth_d = res_wealth_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          frac_d = s_axis_tdata[31:0];
          idx_d  = s_axis_tdata[41:32];
          case (s_axis_tuser)
            OP_INIT: state_d = ST_INIT_PW;
            OP_STEP: state_d = ST_MUL_LO;
            OP_READ: state_d = ST_READ;
            default: ;
          endcase
        end
      end
      ST_INIT_PW: begin
        if (pw_rsp.done) begin
          pw_d    = pw_rsp.power;
          sat_d   = pw_rsp.sat;
          acc_d   = '0;
          i_d     = '0;
          state_d = ST_INIT_FILL;
        end
      end
      ST_INIT_FILL: begin
        acc_d = fill_sum;
        i_d   = i_q + AW'(1);
        if (NW'(i_q) + NW'(1) == n_act) begin
          total_d      = fill_sum;
          res_idx_d    = '0;
          res_wealth_d = init_wealth_q;
          state_d      = ST_RESULT;
        end
      end
      ST_MUL_LO: begin
        plo_d   = 64'(frac_q) * 64'(total_q[31:0]);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        phi_d   = 64'(frac_q) * 64'(total_q[63:32]);
        state_d = ST_TGT;
      end
      ST_TGT: begin
        // Prefix entry zero is being read this cycle.
        target_d = phi_q + {32'd0, plo_q[63:32]};
        state_d  = ST_CHK0;
      end
      ST_CHK0: begin
        if (prefix_rd_q >= target_q) begin
          ci_d    = '0;
          state_d = ST_RDW;
        end else begin
          state_d = ST_CHKN;
        end
      end
      ST_CHKN: begin
        if (prefix_rd_q <= target_q) begin
          ci_d    = nm1;
          state_d = ST_RDW;
        end else begin
          lo_d    = '0;
          hi_d    = nm1;
          state_d = ST_BS_ISSUE;
        end
      end
      ST_BS_ISSUE: begin
        if (hi_q - lo_q > AW'(1)) begin
          mid_d   = AW'(lo_q + ((hi_q - lo_q) >> 1));
          state_d = ST_BS_CMP;
        end else begin
          ci_d    = hi_q;
          state_d = ST_RDW;
        end
      end
      ST_BS_CMP: begin
        if (prefix_rd_q >= target_q) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q;
        end
        state_d = ST_BS_ISSUE;
      end
      ST_RDW: begin
        state_d = ST_PWR_START;
      end
      ST_PWR_START: begin
        // The power unit starts this cycle on the updated wealth.
        w_d     = w_new;
        old_d   = power_rd_q;
        state_d = ST_PWR_WAIT;
      end
      ST_PWR_WAIT: begin
        if (pw_rsp.done) begin
          sat_d    = pw_rsp.sat;
          delta_d  = pw_delta;
          total_d  = total_q + pw_delta;
          rd_ptr_d = NW'(ci_q);
          pend_d   = 1'b0;
          state_d  = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // Read one prefix entry per cycle and write the previous one back.
        if (rd_ptr_q < n_act) begin
          pend_d      = 1'b1;
          pend_addr_d = rd_ptr_q[AW-1:0];
          rd_ptr_d    = rd_ptr_q + NW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            res_idx_d    = IDX_W'(ci_q);
            res_wealth_d = w_q;
            state_d      = ST_RESULT;
          end
        end
      end
      ST_READ: begin
        res_idx_d    = idx_q;
        res_wealth_d = idx_in_range ? wealth_rd_q : '0;
        sat_d        = 1'b0;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, sat_q, total_q, res_wealth_q, res_idx_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      frac_q       <= '0;
      idx_q        <= '0;
      total_q      <= '0;
      acc_q        <= '0;
      pw_q         <= '0;
      sat_q        <= 1'b0;
      i_q          <= '0;
      plo_q        <= '0;
      phi_q        <= '0;
      target_q     <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      ci_q         <= '0;
      w_q          <= '0;
      old_q        <= '0;
      delta_q      <= '0;
      rd_ptr_q     <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      res_idx_q    <= '0;
      res_wealth_q <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      frac_q       <= frac_d;
      idx_q        <= idx_d;
      total_q      <= total_d;
      acc_q        <= acc_d;
      pw_q         <= pw_d;
      sat_q        <= sat_d;
      i_q          <= i_d;
      plo_q        <= plo_d;
      phi_q        <= phi_d;
      target_q     <= target_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      mid_q        <= mid_d;
      ci_q         <= ci_d;
      w_q          <= w_d;
      old_q        <= old_d;
      delta_q      <= delta_d;
      rd_ptr_q     <= rd_ptr_d;
      pend_q       <= pend_d;
      pend_addr_q  <= pend_addr_d;
      res_idx_q    <= res_idx_d;
      res_wealth_q <= res_wealth_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q    <= 11'd1000;
      init_wealth_q <= 40'd65536;
      wealth_step_q <= 40'd655;
      exponent_q    <= 16'd8192;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POP_SIZE:    pop_size_q    <= cfg_wdata_i[POP_W-1:0];
        CFG_INIT_WEALTH: init_wealth_q <= cfg_wdata_i;
        CFG_WEALTH_STEP: wealth_step_q <= cfg_wdata_i;
        CFG_EXPONENT:    exponent_q    <= cfg_wdata_i[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[hw/rtl/wrsu_power.sv]
// ----------------------------------------------------------------------------
// Power unit
// Iterative wealth^exponent through log2 by repeated squaring and exp2 by a
// product of root constants. Separate multipliers for squaring, the exponent product and the root product.
// ----------------------------------------------------------------------------
module wrsu_power (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wrsu_pkg::EXP_W-1:0]    exponent_i,
  input  wrsu_pkg::pw_req_t             req_i,
  output wrsu_pkg::pw_rsp_t             rsp_o
);
  import wrsu_pkg::*;

  typedef enum logic [2:0] {
    PW_IDLE, PW_NORM, PW_LOG, PW_MULY, PW_EXP, PW_FIN, PW_DONE
  } pw_state_e;

  pw_state_e            state_q, state_d;
  logic [WEALTH_W-1:0]  w_q, w_d;
  logic [5:0]           p_q, p_d;
  logic [31:0]          m_q, m_d;
  logic [15:0]          frac_q, frac_d;
  logic [3:0]           cnt_q, cnt_d;
  logic signed [39:0]   prod_q, prod_d;
  logic [31:0]          r_q, r_d;
  logic [POWER_W-1:0]   res_q, res_d;
  logic                 sat_q, sat_d;

  logic [63:0]          sq;
  logic [32:0]          sq_sh;
  logic signed [22:0]   lg;
  logic [63:0]          rc;
  logic signed [11:0]   k;
  logic signed [12:0]   s;
  logic signed [12:0]   ns;
  logic [63:0]          shl;
  logic [31:0]          shr;

  // Datapath helpers.
  always_comb begin
    sq    = 64'(m_q) * 64'(m_q);
    sq_sh = sq[63:31];
    lg    = $signed({1'b0, p_q}) * 23'sd65536 - 23'sd1048576 + $signed({7'd0, frac_q});
    rc    = 64'(r_q) * 64'(EXP_C[cnt_q]);
    k     = prod_q[39:28];
    s     = $signed({k[11], k}) - 13'sd14;
    ns    = -s;
    shl   = 64'(r_q) << s[4:0];
    shr   = r_q >> ns[4:0];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    p_d     = p_q;
    m_d     = m_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    r_d     = r_q;
    res_d   = res_q;
    sat_d   = sat_q;
    unique case (state_q)
      PW_IDLE: begin
        if (req_i.start) begin
          sat_d = 1'b0;
          if (exponent_i == '0) begin
            res_d   = POWER_ONE;
            state_d = PW_DONE;
          end else if (req_i.wealth == '0) begin
            res_d   = '0;
            state_d = PW_DONE;
          end else begin
            w_d     = req_i.wealth;
            p_d     = 6'd39;
            state_d = PW_NORM;
          end
        end
      end
      PW_NORM: begin
        if (w_q[WEALTH_W-1]) begin
          m_d     = w_q[WEALTH_W-1:8];
          cnt_d   = '0;
          frac_d  = '0;
          state_d = PW_LOG;
        end else begin
          w_d = w_q << 1;
          p_d = p_q - 6'd1;
        end
      end
      PW_LOG: begin
        frac_d = {frac_q[14:0], sq_sh[32]};
        m_d    = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = PW_MULY;
        end
      end
      PW_MULY: begin
        prod_d  = 40'(lg * $signed({1'b0, exponent_i}));
        r_d     = 32'd1 << 30;
        cnt_d   = '0;
        state_d = PW_EXP;
      end
      PW_EXP: begin
        if (prod_q[5'd27 - 5'(cnt_q)]) begin
          r_d = rc[61:30];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = PW_FIN;
        end
      end
      PW_FIN: begin
        if (s >= 13'sd18) begin
          res_d = POWER_MAX;
          sat_d = 1'b1;
        end else if (s >= 13'sd0) begin
          if (shl > 64'(POWER_MAX)) begin
            res_d = POWER_MAX;
            sat_d = 1'b1;
          end else begin
            res_d = shl[POWER_W-1:0];
          end
        end else if (ns >= 13'sd32) begin
          res_d = '0;
        end else begin
          res_d = 48'(shr);
        end
        state_d = PW_DONE;
      end
      PW_DONE: begin
        state_d = PW_IDLE;
      end
      default: state_d = PW_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PW_IDLE;
      w_q     <= '0;
      p_q     <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      prod_q  <= '0;
      r_q     <= '0;
      res_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      p_q     <= p_d;
      m_q     <= m_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
      prod_q  <= prod_d;
      r_q     <= r_d;
      res_q   <= res_d;
      sat_q   <= sat_d;
    end
  end

  assign rsp_o.done  = (state_q == PW_DONE);
  assign rsp_o.power = res_q;
  assign rsp_o.sat   = sat_q;

endmodule

[hw/rtl/wrsu_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the weighted roulette sampler
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "weighted_roulette_sampler_update_macros.svh"

module wrsu_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [wrsu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import wrsu_pkg::*;

  // A held result stays presented.
  `WRSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A held result keeps its payload.
  `WRSU_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // A real operation makes the block busy in the next cycle.
  `WRSU_ASSERT_NEXT(a_busy_after_op, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_INIT || s_axis_tuser == OP_STEP || s_axis_tuser == OP_READ), !s_axis_tready)

  // Saturation is only possible for a nonzero wealth.
  `WRSU_ASSERT_IMPL(a_sat_wealth, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[114], m_axis_tdata[49:10] != 40'd0)

endmodule

bind weighted_roulette_sampler_update wrsu_checker u_wrsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/weighted_roulette_sampler_update_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted roulette sampler checker
// Watches the configuration port and both streams, keeps its own copy of the
// wealth, power and prefix-sum tables, predicts each result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module weighted_roulette_sampler_update_checker
  import wrsu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [WEALTH_W-1:0]    cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // tdata: random_fraction [31:0], entry_index [41:32], zero pad [47:42]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation [1:0]
  input  logic [1:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: chosen_index [9:0], entry_wealth [49:10], total_power [113:50],
  // power_saturated [114], zero pad [119:115]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct {
    logic [IDX_W-1:0]    index;
    logic [WEALTH_W-1:0] wealth;
    logic [SUM_W-1:0]    total;
    logic                sat;
  } sample_t;

  sample_t expected_q[$];

  // Shadow configuration and tables.
  logic [POP_W-1:0]    pop_size;
  logic [WEALTH_W-1:0] init_wealth;
  logic [WEALTH_W-1:0] step_wealth;
  logic [EXP_W-1:0]    exp_value;
  logic [WEALTH_W-1:0] wealth_tab [MAX_POPULATION_DEF];
  logic [POWER_W-1:0]  power_tab  [MAX_POPULATION_DEF];
  logic [SUM_W-1:0]    prefix_tab [MAX_POPULATION_DEF];
  logic [SUM_W-1:0]    total_sum;
  logic [63:0]         root_chain [1:16];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Roots 2^(2^-i) in UQ2.30, each one taken from the previous.
  initial begin
    logic [63:0] c;
    c = int_sqrt(64'd1 << 61);
    for (int i = 1; i <= 16; i++) begin
      root_chain[i] = c;
      c = int_sqrt(c << 30);
    end
  end

  // wealth^exponent through a bitwise log2 and a product of roots for exp2.
  function automatic logic [POWER_W-1:0] entry_power(input logic [WEALTH_W-1:0] w,
                                                      input logic [EXP_W-1:0] e,
                                                      output logic sat);
    int          p;
    int          k;
    int          s;
    logic [63:0] m;
    logic [15:0] fr;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] val;
    longint      lg;
    longint      prod;
    sat = 1'b0;
    if (e == 0) return POWER_ONE;
    if (w == 0) return '0;
    p = 39;
    while (!w[p]) p--;
    m = (p >= 31) ? ({24'b0, w} >> (p - 31)) : ({24'b0, w} << (31 - p));
    fr = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      fr = {fr[14:0], 1'b0};
      if (m >= 64'h1_0000_0000) begin
        fr[0] = 1'b1;
        m = m >> 1;
      end
    end
    lg = longint'(p - 16) * 65536 + longint'({48'b0, fr});
    prod = lg * longint'({48'b0, e});
    // The offset keeps the shift a floor for negative logarithms.
    u = 64'(prod + (longint'(1) << 40)) >> 12;
    k = int'(u >> 16) - 4096;
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if (u[16 - i]) r = (r * root_chain[i]) >> 30;
    end
    s = k - 14;
    if (s >= 18) begin
      sat = 1'b1;
      return POWER_MAX;
    end
    if (s >= 0) val = r << s;
    else if (-s >= 64) val = '0;
    else val = r >> (-s);
    if (val > {16'b0, POWER_MAX}) begin
      sat = 1'b1;
      return POWER_MAX;
    end
    return val[POWER_W-1:0];
  endfunction

  // Applies one operation to the shadow tables and returns its result.
  function automatic sample_t apply_operation(input logic [1:0] op,
                                               input logic [FRAC_W-1:0] frac,
                                               input logic [IDX_W-1:0] idx);
    sample_t     res;
    int          n;
    int          ci;
    int          lo_i;
    int          hi_i;
    int          mid;
    logic        sat;
    logic [63:0] pw;
    logic [63:0] acc;
    logic [63:0] target;
    logic [63:0] w;
    logic [63:0] delta;
    n = (pop_size < 1) ? 1 : (pop_size > MAX_POPULATION_DEF) ? MAX_POPULATION_DEF : pop_size;
    sat = 1'b0;
    if (op == OP_INIT) begin
      pw = {16'b0, entry_power(init_wealth, exp_value, sat)};
      acc = '0;
      for (int i = 0; i < n; i++) begin
        wealth_tab[i] = init_wealth;
        power_tab[i] = pw[POWER_W-1:0];
        acc = acc + pw;
        prefix_tab[i] = acc;
      end
      total_sum = acc;
      res.index = '0;
      res.wealth = init_wealth;
    end else if (op == OP_STEP) begin
      target = {32'b0, frac} * {32'b0, total_sum[63:32]}
             + (({32'b0, frac} * {32'b0, total_sum[31:0]}) >> 32);
      if (prefix_tab[0] >= target) ci = 0;
      else if (prefix_tab[n - 1] <= target) ci = n - 1;
      else begin
        lo_i = 0;
        hi_i = n - 1;
        while (hi_i - lo_i > 1) begin
          mid = lo_i + (hi_i - lo_i) / 2;
          if (prefix_tab[mid] >= target) hi_i = mid;
          else lo_i = mid;
        end
        ci = hi_i;
      end
      // Wealth saturates at its all-ones value.
      w = {24'b0, wealth_tab[ci]} + {24'b0, step_wealth};
      if (w > {24'b0, WEALTH_MAX}) w = {24'b0, WEALTH_MAX};
      wealth_tab[ci] = w[WEALTH_W-1:0];
      pw = {16'b0, entry_power(w[WEALTH_W-1:0], exp_value, sat)};
      delta = pw - {16'b0, power_tab[ci]};
      power_tab[ci] = pw[POWER_W-1:0];
      total_sum = total_sum + delta;
      for (int j = ci; j < n; j++) prefix_tab[j] = prefix_tab[j] + delta;
      res.index = ci[IDX_W-1:0];
      res.wealth = w[WEALTH_W-1:0];
    end else begin
      res.index = idx;
      res.wealth = wealth_tab[idx];
    end
    res.total = total_sum;
    res.sat = sat;
    return res;
  endfunction

  initial begin
    pop_size = 11'd1000;
    init_wealth = 40'd65536;
    step_wealth = 40'd655;
    exp_value = 16'd8192;
    total_sum = '0;
    fail_count_o = 0;
    for (int i = 0; i < MAX_POPULATION_DEF; i++) begin
      wealth_tab[i] = '0;
      power_tab[i] = '0;
      prefix_tab[i] = '0;
    end
  end

  assign pending_o = expected_q.size();

  // Configuration writes, accepted input transfers and result transfers.
  always @(posedge clk_i) begin
    sample_t exp_s;
    sample_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POP_SIZE:    pop_size = cfg_wdata_i[POP_W-1:0];
          CFG_INIT_WEALTH: init_wealth = cfg_wdata_i;
          CFG_WEALTH_STEP: step_wealth = cfg_wdata_i;
          CFG_EXPONENT:    exp_value = cfg_wdata_i[EXP_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready &&
          (s_axis_tuser == OP_INIT || s_axis_tuser == OP_STEP || s_axis_tuser == OP_READ)) begin
        expected_q.push_back(apply_operation(s_axis_tuser, s_axis_tdata[31:0],
                                             s_axis_tdata[41:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[9:0];
        got.wealth = m_axis_tdata[49:10];
        got.total = m_axis_tdata[113:50];
        got.sat = m_axis_tdata[114];
        if (expected_q.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fail_count_o++;
        end else begin
          exp_s = expected_q.pop_front();
          if (got.index !== exp_s.index) begin
            $error("chosen_index: expected %0d, got %0d", exp_s.index, got.index);
            fail_count_o++;
          end
          if (got.wealth !== exp_s.wealth) begin
            $error("entry_wealth: expected %0h, got %0h", exp_s.wealth, got.wealth);
            fail_count_o++;
          end
          if (got.total !== exp_s.total) begin
            $error("total_power: expected %0h, got %0h", exp_s.total, got.total);
            fail_count_o++;
          end
          if (got.sat !== exp_s.sat) begin
            $error("power_saturated: expected %0b, got %0b", exp_s.sat, got.sat);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[tb/weighted_roulette_sampler_update_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted roulette sampler testbench
// Drives directed corner phases and then random phases of init, step and read
// operations under random idling on both streams; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module weighted_roulette_sampler_update_test;
  import wrsu_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 250;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [1:0]             cfg_index_i;
  logic [WEALTH_W-1:0]    cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     fail_count;
  int                     pending;

  int   items_sent;
  int   active_n;
  int   hold_req;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;
  bit   calm;

  weighted_roulette_sampler_update dut (.*);

  weighted_roulette_sampler_update_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [FRAC_W-1:0] frac,
                           input logic [IDX_W-1:0] idx);
    while (!calm && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, idx, frac};
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Reconfigures the idle block and loads the table with an init.
  task automatic start_phase(input logic [POP_W-1:0] pop, input logic [WEALTH_W-1:0] iw,
                             input logic [WEALTH_W-1:0] ws, input logic [EXP_W-1:0] ex);
    logic [WEALTH_W-1:0] vals [4];
    logic [1:0]          regs [4];
    wait_idle();
    vals = '{{29'b0, pop}, iw, ws, {24'b0, ex}};
    regs = '{CFG_POP_SIZE, CFG_INIT_WEALTH, CFG_WEALTH_STEP, CFG_EXPONENT};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_wdata_i <= vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    active_n = (pop < 1) ? 1 : (pop > MAX_POPULATION_DEF) ? MAX_POPULATION_DEF : pop;
    send_item(OP_INIT, $urandom, IDX_W'($urandom));
  endtask

  function automatic logic [WEALTH_W-1:0] pick_wealth();
    case ($urandom_range(3))
      0: return WEALTH_W'($urandom_range(0, 1 << 20));
      1: return {8'($urandom_range(0, 255)), $urandom};
      2: return WEALTH_W'($urandom_range(1 << 16, 1 << 22));
      default: return WEALTH_W'($urandom);
    endcase
  endfunction

  initial begin
    int big_phases;
    int pick;
    logic [POP_W-1:0] pop;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_POP_SIZE;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_INIT;
    m_axis_tready = 1'b0;
    items_sent = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    big_phases = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default-like setting: fraction extremes, unused code, reads.
    start_phase(11'd4, 40'd65536, 40'd655, 16'd8192);
    send_item(OP_READ, 32'd0, 10'd0);
    send_item(OP_STEP, 32'd0, 10'd0);
    send_item(OP_STEP, 32'hFFFF_FFFF, 10'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 10'h3FF);
    send_item(OP_STEP, 32'h8000_0000, 10'd0);
    send_item(OP_READ, 32'd0, 10'd3);
    // Zero exponent and zero wealth give unit power.
    start_phase(11'd2, 40'd0, 40'd0, 16'd0);
    send_item(OP_STEP, 32'h4000_0000, 10'd0);
    send_item(OP_READ, 32'd0, 10'd1);
    // Maximum wealth and exponent: power and wealth both saturate.
    start_phase(11'd3, WEALTH_MAX, WEALTH_MAX, 16'hFFFF);
    send_item(OP_STEP, 32'h1234_5678, 10'd0);
    send_item(OP_READ, 32'd0, 10'd2);
    // Population below range clamps to one entry; zero wealth, nonzero exponent.
    start_phase(11'd0, 40'd0, 40'd1, 16'd4096);
    send_item(OP_STEP, 32'hFFFF_FFFF, 10'd0);
    send_item(OP_STEP, 32'd0, 10'd0);
    send_item(OP_READ, 32'd0, 10'd0);
    // Population above range clamps to the full table.
    start_phase(11'd2047, 40'd3, 40'hFF_FFFF_FFFF, 16'd1);
    send_item(OP_STEP, 32'hFFFF_FFFF, 10'd0);
    send_item(OP_READ, 32'd0, 10'd1023);

    // Random phases, mostly small tables.
    for (int ph = 0; items_sent < 525; ph++) begin
      calm = (ph >= 4 && ph <= 6);
      pick = $urandom_range(19);
      if (pick == 0 && big_phases < 3) begin
        big_phases++;
        pop = 11'd1024;
      end else begin
        pop = POP_W'($urandom_range(2, 24));
      end
      start_phase(pop, pick_wealth(), pick_wealth(),
                  ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(1024, 16384)));
      for (int i = 0; i < 30; i++) begin
        if (ph == 1 && i == 5) hold_req++;
        pick = $urandom_range(99);
        if (pick < 70) send_item(OP_STEP, $urandom, IDX_W'($urandom));
        else if (pick < 90) send_item(OP_READ, $urandom, IDX_W'($urandom_range(0, active_n - 1)));
        else if (pick < 95) send_item(OP_UNUSED, $urandom, IDX_W'($urandom));
        else send_item(OP_INIT, $urandom, IDX_W'($urandom));
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
